// ----- rtl/ued_pkg.sv -----
package ued_pkg;

    localparam int CHAR_W = 21;
    localparam int DIGITS = 3;
    localparam int CNT_W  = 3;   // holds up to six results per transaction

    localparam logic [CHAR_W-1:0] BACKSLASH_C = CHAR_W'(32'h5C);
    localparam logic [CHAR_W-1:0] LETTER_U_C  = CHAR_W'(32'h75);

    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              text_last;
    } in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              run_last;
        logic              text_end;
    } out_t;

    // One transaction's worth of results: a prefix of the held sequence
    // (backslash, 'u', digit 0..2) followed by an optional tail character.
    typedef struct packed {
        logic [CNT_W-1:0]               held_cnt;
        logic                           tail_vld;
        logic [CHAR_W-1:0]              tail_char;
        logic [DIGITS-1:0][CHAR_W-1:0]  digits;
        logic                           last;
    } burst_t;

    function automatic logic hex_ok(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
               (b >= 8'h41 && b <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] t;
        priority if (b >= 8'h30 && b <= 8'h39) begin
            t = b - 8'h30;
        end else if (b >= 8'h61 && b <= 8'h66) begin
            t = b - 8'h57;
        end else if (b >= 8'h41 && b <= 8'h46) begin
            t = b - 8'h37;
        end else begin
            t = 8'h00;
        end
        return t[3:0];
    endfunction

endpackage

// ----- rtl/ued_core.sv -----
module ued_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ued_pkg::in_t   s_data,
    input  logic           burst_free,
    output logic           burst_load,
    output ued_pkg::burst_t burst_data
);
    import ued_pkg::*;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_BS   = 3'd1;
    localparam logic [2:0] PH_U    = 3'd2;
    localparam logic [2:0] PH_D1   = 3'd3;
    localparam logic [2:0] PH_D2   = 3'd4;
    localparam logic [2:0] PH_D3   = 3'd5;

    logic                           in_vld_reg;
    in_t                            in_reg;
    logic [2:0]                     phase_reg;
    logic [2:0]                     phase_mid;
    logic [2:0]                     phase_next;
    logic [DIGITS-1:0][CHAR_W-1:0]  dig_reg;
    logic [DIGITS-1:0][CHAR_W-1:0]  dig_next;

    logic              advance;
    logic [CHAR_W-1:0] c;
    logic              is_bs;
    logic              is_u;
    logic              is_hex;
    logic              restart;
    logic              wr;
    logic [1:0]        wr_idx;
    logic [2:0]        wr_off;
    logic [CNT_W-1:0]  k;
    logic              tail_vld;
    logic [CHAR_W-1:0] tail_char;
    logic [CHAR_W-1:0] code_point;

    assign advance = in_vld_reg && burst_free;
    assign s_ready = !in_vld_reg || burst_free;

    assign c      = in_reg.char_in;
    assign is_bs  = (c == BACKSLASH_C);
    assign is_u   = (c == LETTER_U_C);
    assign is_hex = hex_ok(c[7:0]);
    assign wr_off = phase_reg - PH_U;
    assign wr_idx = wr_off[1:0];

    assign code_point = {5'b0, hex_val(dig_reg[0][7:0]), hex_val(dig_reg[1][7:0]),
                         hex_val(dig_reg[2][7:0]), hex_val(c[7:0])};

    always_comb begin
        restart   = 1'b0;
        wr        = 1'b0;
        k         = '0;
        tail_vld  = 1'b0;
        tail_char = c;
        phase_mid = PH_IDLE;
        unique case (phase_reg)
            PH_IDLE: begin
                restart = 1'b1;
            end
            PH_BS: begin
                if (is_u) begin
                    phase_mid = PH_U;
                end else begin
                    k       = CNT_W'(1);
                    restart = 1'b1;
                end
            end
            PH_U, PH_D1, PH_D2: begin
                if (is_hex) begin
                    wr        = 1'b1;
                    phase_mid = phase_reg + 3'd1;
                end else begin
                    k       = phase_reg;
                    restart = 1'b1;
                end
            end
            PH_D3: begin
                if (is_hex) begin
                    tail_vld  = 1'b1;
                    tail_char = code_point;
                end else begin
                    k       = phase_reg;
                    restart = 1'b1;
                end
            end
            default: begin
                // unreachable phases release everything held
                k       = CNT_W'(5);
                restart = 1'b1;
            end
        endcase

        // examine the character again as if nothing were held
        if (restart) begin
            if (is_bs) begin
                phase_mid = PH_BS;
            end else begin
                tail_vld = 1'b1;
            end
        end

        // flush what is still held at the end of the text
        if (in_reg.text_last && phase_mid != PH_IDLE) begin
            if (k == '0) begin
                k = phase_mid;
            end else begin
                tail_vld = 1'b1;
            end
        end
        phase_next = in_reg.text_last ? PH_IDLE : phase_mid;
    end

    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            dig_next[i] = (wr && wr_idx == 2'(i)) ? c : dig_reg[i];
        end
    end

    assign burst_load           = advance && (k != '0 || tail_vld);
    assign burst_data.held_cnt  = k;
    assign burst_data.tail_vld  = tail_vld;
    assign burst_data.tail_char = tail_char;
    assign burst_data.digits    = dig_next;
    assign burst_data.last      = in_reg.text_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            phase_reg  <= PH_IDLE;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (advance) begin
                phase_reg <= phase_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            dig_reg <= dig_next;
        end
    end

endmodule

// ----- rtl/ued_burst.sv -----
module ued_burst (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            burst_load,
    input  ued_pkg::burst_t burst_data,
    output logic            burst_free,
    output logic            m_valid,
    input  logic            m_ready,
    output ued_pkg::out_t   m_data
);
    import ued_pkg::*;

    logic             b_vld_reg;
    burst_t           b_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] dig_off;
    logic             at_last;
    logic [CHAR_W-1:0] held_char;

    assign cnt     = b_reg.held_cnt + CNT_W'(b_reg.tail_vld);
    assign at_last = (idx_reg == cnt - CNT_W'(1));
    assign dig_off = idx_reg - CNT_W'(2);

    assign burst_free = !b_vld_reg || (m_ready && at_last);
    assign m_valid    = b_vld_reg;

    always_comb begin
        unique case (idx_reg)
            CNT_W'(0): held_char = BACKSLASH_C;
            CNT_W'(1): held_char = LETTER_U_C;
            CNT_W'(2), CNT_W'(3), CNT_W'(4): held_char = b_reg.digits[dig_off[1:0]];
            default:   held_char = b_reg.tail_char;
        endcase
    end

    assign m_data.char_out = (idx_reg < b_reg.held_cnt) ? held_char : b_reg.tail_char;
    assign m_data.run_last = at_last;
    assign m_data.text_end = at_last && b_reg.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (burst_load) begin
            b_vld_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (b_vld_reg && m_ready) begin
            if (at_last) begin
                b_vld_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (burst_load) begin
            b_reg <= burst_data;
        end
    end

endmodule

// ----- rtl/unicode_escape_decoder_unit.sv -----
// Decodes backslash-u-four-hex escapes in a stream of 21-bit characters,
// one character per input transaction, with text_last on the final one.
// Each completed escape becomes its 16-bit code point; a partial escape is
// held and released unchanged when it fails or when the text ends. An input
// transaction moves through an input register and the decode logic into a
// result register, one per cycle while that register is free; it then
// hands out the transaction's results one per cycle while m_ready is high
// (none to six). Transactions giving zero or one result sustain one per
// cycle; one giving n results holds the result register until all n are
// taken, the input stalling after one more transaction is taken. The
// result register loads when the input register holds a transaction and
// it is free, and offers its first result as soon as it loads. run_last
// marks a transaction's last result and text_end the final one of the text.
module unicode_escape_decoder_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ued_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output ued_pkg::out_t m_data
);
    import ued_pkg::*;

    logic   burst_free;
    logic   burst_load;
    burst_t burst_data;

    ued_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .burst_free (burst_free),
        .burst_load (burst_load),
        .burst_data (burst_data)
    );

    ued_burst u_burst (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .burst_load (burst_load),
        .burst_data (burst_data),
        .burst_free (burst_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
